FILE: sv/tftc_pkg.sv
// ----------------------------------------------------------------------------
// tftc_pkg
// Types, constants and the keyword table of the text frame tokenizer.
// ----------------------------------------------------------------------------
package tftc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned KEY_CNT_W  = 4;
    localparam int unsigned LABEL_MAX  = 8;
    localparam int unsigned VALUE_MAX  = 32;
    localparam int unsigned KEY_LEN    = 8;
    localparam int unsigned POS_SAT    = 63;
    localparam int unsigned POS_SHOW   = 32;

    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

    typedef enum logic [2:0] {
        ROLE_OUTSIDE = 3'd0,
        ROLE_LABEL   = 3'd1,
        ROLE_VALUE   = 3'd2,
        ROLE_TAB     = 3'd3,
        ROLE_LF      = 3'd4,
        ROLE_CR      = 3'd5,
        ROLE_CHECK   = 3'd6,
        ROLE_DROP    = 3'd7
    } role_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_LABEL = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_CHECK = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        role_t             byte_role;
        logic [POS_W-1:0]  char_position;
        logic              field_done;
        logic              line_bad;
        logic              block_done;
        logic              block_ok;
    } result_t;

    function automatic logic [BYTE_W-1:0] keyword_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h43; // C
            3'd1:    c = 8'h68; // h
            3'd2:    c = 8'h65; // e
            3'd3:    c = 8'h63; // c
            3'd4:    c = 8'h6B; // k
            3'd5:    c = 8'h73; // s
            3'd6:    c = 8'h75; // u
            default: c = 8'h6D; // m
        endcase
        return c;
    endfunction

endpackage

FILE: sv/text_frame_tokenizer_checksum_core.sv
// ----------------------------------------------------------------------------
// text_frame_tokenizer_checksum_core
// Tags each received byte of a LF/label/TAB/value/CR text frame and checks
// the block checksum.
// ----------------------------------------------------------------------------
//  channel | ports                     | direction
//  --------+---------------------------+----------
//  s_      | valid, ready, rx_byte     | in
//  m_      | valid, ready, echo_byte,  | out
//          | byte_role, char_position, |
//          | field_done, line_bad,     |
//          | block_done, block_ok      |
//
//  One item per cycle sustained while m_ready stays high.
//  Input register, combinational parse step, result register.
//  Reset (aresetn low, synchronous) empties both registers, idles the line.
//  A stall on m_ready fills the result register, then the input register,
//  then drops s_ready; no item is lost.
// ----------------------------------------------------------------------------
module text_frame_tokenizer_checksum_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_echo_byte,
    output logic [2:0]  m_byte_role,
    output logic [5:0]  m_char_position,
    output logic        m_field_done,
    output logic        m_line_bad,
    output logic        m_block_done,
    output logic        m_block_ok
);

    logic                        advance;
    logic                        in_vld;
    logic [tftc_pkg::BYTE_W-1:0] in_byte;
    tftc_pkg::result_t           result;
    tftc_pkg::result_t           out_item;

    tftc_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_vld    (in_vld),
        .in_byte   (in_byte)
    );

    tftc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_byte (in_byte),
        .result  (result)
    );

    tftc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (in_vld),
        .result   (result),
        .advance  (advance),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .out_item (out_item)
    );

    assign m_echo_byte     = out_item.echo_byte;
    assign m_byte_role     = out_item.byte_role;
    assign m_char_position = out_item.char_position;
    assign m_field_done    = out_item.field_done;
    assign m_line_bad      = out_item.line_bad;
    assign m_block_done    = out_item.block_done;
    assign m_block_ok      = out_item.block_ok;

endmodule

FILE: sv/tftc_in_stage.sv
// ----------------------------------------------------------------------------
// tftc_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module tftc_in_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tftc_pkg::BYTE_W-1:0]  s_rx_byte,
    input  logic                         advance,
    output logic                         in_vld,
    output logic [tftc_pkg::BYTE_W-1:0]  in_byte
);

    logic                        vld_reg;
    logic                        vld_next;
    logic [tftc_pkg::BYTE_W-1:0] byte_reg;
    logic                        load;

    assign s_ready  = !vld_reg || advance;
    assign load     = s_valid && s_ready;
    assign vld_next = load || (vld_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign in_vld  = vld_reg;
    assign in_byte = byte_reg;

endmodule

FILE: sv/tftc_parser.sv
// ----------------------------------------------------------------------------
// tftc_parser
// Line state, keyword match and running sum; tags one byte per advance.
// ----------------------------------------------------------------------------
module tftc_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [tftc_pkg::BYTE_W-1:0]  in_byte,
    output tftc_pkg::result_t            result
);

    tftc_pkg::phase_t                  phase_reg, phase_next;
    logic [tftc_pkg::BYTE_W-1:0]       sum_reg, sum_next;
    logic [tftc_pkg::KEY_CNT_W-1:0]    key_reg, key_next;
    logic                              miss_reg, miss_next;
    logic [tftc_pkg::POS_W-1:0]        pos_reg, pos_next;

    logic [tftc_pkg::BYTE_W-1:0]       sum_add;
    logic [tftc_pkg::POS_W-1:0]        pos_shown;
    logic [tftc_pkg::POS_W-1:0]        pos_inc;
    logic                              key_full;

    assign sum_add   = sum_reg + in_byte;
    assign pos_shown = (pos_reg > tftc_pkg::POS_W'(tftc_pkg::POS_SHOW))
                       ? tftc_pkg::POS_W'(tftc_pkg::POS_SHOW) : pos_reg;
    assign pos_inc   = (pos_reg < tftc_pkg::POS_W'(tftc_pkg::POS_SAT))
                       ? pos_reg + 1'b1 : pos_reg;
    assign key_full  = (key_reg == tftc_pkg::KEY_CNT_W'(tftc_pkg::KEY_LEN));

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_add;
        key_next   = key_reg;
        miss_next  = miss_reg;
        pos_next   = pos_reg;

        result               = '0;
        result.echo_byte     = in_byte;
        result.byte_role     = tftc_pkg::ROLE_OUTSIDE;

        case (phase_reg)
            tftc_pkg::PH_IDLE: begin
                if (in_byte == tftc_pkg::CH_LF) begin
                    result.byte_role = tftc_pkg::ROLE_LF;
                    phase_next = tftc_pkg::PH_LABEL;
                    pos_next   = '0;
                    key_next   = '0;
                    miss_next  = 1'b0;
                end else if (in_byte == tftc_pkg::CH_CR) begin
                    result.byte_role = tftc_pkg::ROLE_CR;
                end
            end
            tftc_pkg::PH_LABEL: begin
                if (in_byte == tftc_pkg::CH_LF) begin
                    result.byte_role = tftc_pkg::ROLE_LF;
                    pos_next  = '0;
                    key_next  = '0;
                    miss_next = 1'b0;
                end else if (in_byte == tftc_pkg::CH_CR) begin
                    result.byte_role = tftc_pkg::ROLE_CR;
                    result.line_bad  = 1'b1;
                    phase_next = tftc_pkg::PH_IDLE;
                end else if (in_byte == tftc_pkg::CH_TAB) begin
                    result.byte_role = tftc_pkg::ROLE_TAB;
                    phase_next = (key_full && !miss_reg) ? tftc_pkg::PH_CHECK
                                                         : tftc_pkg::PH_VALUE;
                    pos_next   = '0;
                end else begin
                    result.char_position = pos_shown;
                    result.byte_role =
                        (pos_reg >= tftc_pkg::POS_W'(tftc_pkg::LABEL_MAX))
                        ? tftc_pkg::ROLE_DROP : tftc_pkg::ROLE_LABEL;
                    if (!miss_reg && !key_full &&
                        in_byte == tftc_pkg::keyword_char(key_reg[2:0])) begin
                        key_next = key_reg + 1'b1;
                    end else begin
                        miss_next = 1'b1;
                    end
                    pos_next = pos_inc;
                end
            end
            tftc_pkg::PH_VALUE: begin
                if (in_byte == tftc_pkg::CH_LF) begin
                    result.byte_role = tftc_pkg::ROLE_LF;
                    phase_next = tftc_pkg::PH_LABEL;
                    pos_next   = '0;
                    key_next   = '0;
                    miss_next  = 1'b0;
                end else if (in_byte == tftc_pkg::CH_CR) begin
                    result.byte_role  = tftc_pkg::ROLE_CR;
                    result.field_done = 1'b1;
                    phase_next = tftc_pkg::PH_IDLE;
                end else begin
                    result.char_position = pos_shown;
                    result.byte_role =
                        (pos_reg >= tftc_pkg::POS_W'(tftc_pkg::VALUE_MAX))
                        ? tftc_pkg::ROLE_DROP : tftc_pkg::ROLE_VALUE;
                    pos_next = pos_inc;
                end
            end
            default: begin
                // checksum byte closes the block
                result.byte_role  = tftc_pkg::ROLE_CHECK;
                result.block_done = 1'b1;
                result.block_ok   = (sum_add == '0);
                sum_next   = '0;
                phase_next = tftc_pkg::PH_IDLE;
                pos_next   = '0;
                key_next   = '0;
                miss_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tftc_pkg::PH_IDLE;
            sum_reg   <= '0;
            key_reg   <= '0;
            miss_reg  <= 1'b0;
            pos_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            key_reg   <= key_next;
            miss_reg  <= miss_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: sv/tftc_out_stage.sv
// ----------------------------------------------------------------------------
// tftc_out_stage
// Result register: holds one tagged item until the consumer takes it.
// ----------------------------------------------------------------------------
module tftc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_vld,
    input  tftc_pkg::result_t result,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output tftc_pkg::result_t out_item
);

    logic              vld_reg;
    logic              vld_next;
    tftc_pkg::result_t item_reg;

    assign advance  = in_vld && (!vld_reg || m_ready);
    assign vld_next = advance || (vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= result;
        end
    end

    assign m_valid  = vld_reg;
    assign out_item = item_reg;

endmodule

FILE: sv/tftc_checker.sv
// ----------------------------------------------------------------------------
// tftc_checker
// Port-level checks on the tokenizer result channel.
// ----------------------------------------------------------------------------
module tftc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_echo_byte,
    input logic [2:0] m_byte_role,
    input logic [5:0] m_char_position,
    input logic       m_field_done,
    input logic       m_line_bad,
    input logic       m_block_done,
    input logic       m_block_ok
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_echo_byte))
        else $error("result item changed while stalled");

    a_ok_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_block_ok |-> m_block_done &&
            m_byte_role == tftc_pkg::ROLE_CHECK)
        else $error("block_ok without checksum byte");

    a_cr_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_field_done || m_line_bad) |->
            m_byte_role == tftc_pkg::ROLE_CR && !(m_field_done && m_line_bad))
        else $error("line flag on a non-CR item");

    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_position != 6'd0 |->
            m_char_position <= 6'(tftc_pkg::POS_SHOW) &&
            (m_byte_role == tftc_pkg::ROLE_LABEL ||
             m_byte_role == tftc_pkg::ROLE_VALUE ||
             m_byte_role == tftc_pkg::ROLE_DROP))
        else $error("char_position out of place");

endmodule

bind text_frame_tokenizer_checksum_core tftc_checker u_tftc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_echo_byte     (m_echo_byte),
    .m_byte_role     (m_byte_role),
    .m_char_position (m_char_position),
    .m_field_done    (m_field_done),
    .m_line_bad      (m_line_bad),
    .m_block_done    (m_block_done),
    .m_block_ok      (m_block_ok)
);
